>>> src/bta_pkg.sv
// Shared constants, codes and chain types for the bakery ticket arbiter.
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

    localparam int NUM_REQ     = 16;
    localparam int TICKET_BITS = 8;
    localparam int IDX_W       = (NUM_REQ > 1) ? $clog2(NUM_REQ) : 1;

    // fixed field widths on the ports
    localparam int ACTION_W = 1;
    localparam int WHO_W    = 4;
    localparam int STATUS_W = 2;
    localparam int GIVEN_W  = 8;

    localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

    typedef logic [TICKET_BITS-1:0] t_ticket;
    typedef logic [IDX_W-1:0]       t_idx;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REQUEST = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic    valid;
        t_action action;
        logic    who_ok;   // requester index is in range
        t_idx    who;
        t_ticket top;      // largest ticket seen so far
        logic    found;    // a nonzero ticket other than who's was seen
        t_ticket low;      // smallest such ticket
        t_idx    low_idx;
        t_ticket own;      // who's current ticket
    } t_token;

    // Broadcast write into the ticket row
    typedef struct packed {
        logic    en;
        t_idx    idx;
        t_ticket value;
    } t_wr;

endpackage

`default_nettype wire

>>> src/bakery_ticket_arbiter.sv
// Top level: bakery ticket arbiter built as a row of ticket cells swept by a scan token.
//
//   channel | direction | handshake                 | beat fields
//   --------+-----------+---------------------------+--------------------------------------
//   in      | to block  | i_in_valid / o_in_stall   | i_action, i_requester
//   out     | from block| o_out_valid / i_out_stall | o_status, o_ticket_given,
//           |           |                           | o_grant_valid, o_grant_index
//
// The scan token walks the ticket row one cell per cycle; r_fin then latches the tail
// token, and the finish state updates the ticket and loads the result register once
// that register is free. One item is in work at a time.
// Synchronous active-low reset clears all tickets at once; no sweep is needed.
// A stalled result holds in the output register; the next item may enter meanwhile,
// but its update waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module bakery_ticket_arbiter (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [bta_pkg::ACTION_W-1:0]     i_action,
    input  wire logic [bta_pkg::WHO_W-1:0]        i_requester,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [bta_pkg::STATUS_W-1:0]          o_status,
    output logic [bta_pkg::GIVEN_W-1:0]           o_ticket_given,
    output logic                                  o_grant_valid,
    output logic [bta_pkg::WHO_W-1:0]             o_grant_index
);

    bta_pkg::t_state  r_state;
    bta_pkg::t_state  n_state;
    bta_pkg::t_token  w_tok [bta_pkg::NUM_REQ+1];
    bta_pkg::t_token  r_fin;
    bta_pkg::t_wr     w_wr;

    logic             w_accept;
    logic             w_out_free;
    logic             w_commit;

    logic             r_out_valid;
    bta_pkg::t_status r_status;
    bta_pkg::t_ticket r_given;
    logic             r_grant_valid;
    bta_pkg::t_idx    r_grant_idx;

    bta_pkg::t_status w_status;
    bta_pkg::t_ticket w_given;
    bta_pkg::t_ticket w_new_own;
    logic             w_who_wins;
    logic             w_grant_valid;
    bta_pkg::t_idx    w_grant_idx;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // seed token enters cell 0 on the accepting edge
    always_comb begin
        w_tok[0]         = '0;
        w_tok[0].valid   = w_accept;
        w_tok[0].action  = bta_pkg::t_action'(i_action);
        w_tok[0].who_ok  = int'(i_requester) < bta_pkg::NUM_REQ;
        w_tok[0].who     = (bta_pkg::IDX_W)'(i_requester);
    end

    for (genvar g = 0; g < bta_pkg::NUM_REQ; g++) begin : g_cell
        bta_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx ((bta_pkg::IDX_W)'(g)),
            .i_token    (w_tok[g]),
            .i_wr       (w_wr),
            .o_token    (w_tok[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bta_pkg::S_IDLE:   if (w_accept) n_state = bta_pkg::S_SCAN;
            bta_pkg::S_SCAN:   if (w_tok[bta_pkg::NUM_REQ].valid) n_state = bta_pkg::S_FINISH;
            bta_pkg::S_FINISH: if (w_out_free) n_state = bta_pkg::S_IDLE;
            default:           n_state = bta_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_commit   = 1'b0;
        case (r_state)
            bta_pkg::S_IDLE:   o_in_stall = 1'b0;
            bta_pkg::S_SCAN:   o_in_stall = 1'b1;
            bta_pkg::S_FINISH: w_commit   = w_out_free;
            default:           o_in_stall = 1'b1;
        endcase
    end

    // decide the action from the finished scan
    always_comb begin
        w_status  = bta_pkg::ST_OK;
        w_given   = '0;
        w_wr      = '0;
        w_wr.idx  = r_fin.who;
        if (!r_fin.who_ok) begin
            w_status = bta_pkg::ST_IGNORED;
        end else if (r_fin.action == bta_pkg::ACT_REQUEST) begin
            if (r_fin.own != '0) begin
                w_status = bta_pkg::ST_IGNORED;
            end else if (r_fin.top == bta_pkg::TICKET_MAX) begin
                w_status = bta_pkg::ST_OVERFLOW;
            end else begin
                w_given     = r_fin.top + 1'b1;
                w_wr.en     = w_commit;
                w_wr.value  = w_given;
            end
        end else begin
            if (r_fin.own == '0) begin
                w_status = bta_pkg::ST_IGNORED;
            end else begin
                w_wr.en    = w_commit;
                w_wr.value = '0;
            end
        end

        // fold the updated ticket of the acting requester into the grant
        w_new_own = r_fin.own;
        if (r_fin.who_ok && (w_status == bta_pkg::ST_OK)) begin
            w_new_own = (r_fin.action == bta_pkg::ACT_REQUEST) ? w_given : '0;
        end
        w_who_wins = r_fin.who_ok && (w_new_own != '0) &&
                     (!r_fin.found || (w_new_own < r_fin.low) ||
                      ((w_new_own == r_fin.low) && (r_fin.who < r_fin.low_idx)));
        w_grant_valid = w_who_wins || r_fin.found;
        if (w_who_wins) begin
            w_grant_idx = r_fin.who;
        end else if (r_fin.found) begin
            w_grant_idx = r_fin.low_idx;
        end else begin
            w_grant_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bta_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[bta_pkg::NUM_REQ].valid) begin
            r_fin <= w_tok[bta_pkg::NUM_REQ];
        end
        if (w_commit) begin
            r_status      <= w_status;
            r_given       <= w_given;
            r_grant_valid <= w_grant_valid;
            r_grant_idx   <= w_grant_idx;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_ticket_given = (bta_pkg::GIVEN_W)'(r_given);
    assign o_grant_valid  = r_grant_valid;
    assign o_grant_index  = (bta_pkg::WHO_W)'(r_grant_idx);

endmodule

`default_nettype wire

>>> src/bta_cell.sv
// One ticket cell: holds a requester's ticket and folds it into the passing scan token.
`timescale 1ns / 1ps
`default_nettype none

module bta_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bta_pkg::t_idx   i_cell_idx,
    input  wire bta_pkg::t_token i_token,
    input  wire bta_pkg::t_wr    i_wr,
    output bta_pkg::t_token      o_token
);

    bta_pkg::t_ticket r_ticket;
    bta_pkg::t_token  r_token;
    bta_pkg::t_token  n_token;

    always_comb begin
        n_token = i_token;
        if (r_ticket > i_token.top) begin
            n_token.top = r_ticket;
        end
        if (i_token.who_ok && (i_token.who == i_cell_idx)) begin
            n_token.own = r_ticket;
        end else if ((r_ticket != '0) && (!i_token.found || (r_ticket < i_token.low))) begin
            // strict compare keeps the lower index on a tie
            n_token.found   = 1'b1;
            n_token.low     = r_ticket;
            n_token.low_idx = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticket <= '0;
            r_token  <= '0;
        end else begin
            if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
                r_ticket <= i_wr.value;
            end
            r_token <= n_token;
        end
    end

    assign o_token = r_token;

endmodule

`default_nettype wire

>>> src/bta_checker.sv
// Port-level checks for the bakery ticket arbiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bta_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [bta_pkg::STATUS_W-1:0] o_status,
    input wire logic [bta_pkg::GIVEN_W-1:0]  o_ticket_given,
    input wire logic                         o_grant_valid,
    input wire logic [bta_pkg::WHO_W-1:0]    o_grant_index
);

    // one item at a time: accepting a beat closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted beat");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_ticket_given) &&
             $stable(o_grant_valid) && $stable(o_grant_index)))
        else $error("stalled result beat changed");

    // no grant shows index zero
    a_no_grant_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_grant_valid) |-> (o_grant_index == '0))
        else $error("grant index set without a grant");

    // only a successful request hands out a ticket, and it then holds a grant
    a_given: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_ticket_given != '0)) |->
            ((o_status == bta_pkg::ST_OK) && o_grant_valid))
        else $error("ticket given on a refused action or without grant");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == bta_pkg::ST_OK) ||
                         (o_status == bta_pkg::ST_IGNORED) ||
                         (o_status == bta_pkg::ST_OVERFLOW)))
        else $error("undefined status code");

endmodule

bind bakery_ticket_arbiter bta_checker u_bta_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_ticket_given (o_ticket_given),
    .o_grant_valid  (o_grant_valid),
    .o_grant_index  (o_grant_index)
);

`default_nettype wire

>>> bench/bakery_ticket_arbiter_test.sv
// Self-checking testbench for the bakery ticket arbiter: ticket predictor and grant scoreboard.
`timescale 1ns / 1ps

module bakery_ticket_arbiter_test;

    localparam int RANDOM_BEATS = 1280;
    localparam int CALM_BEATS   = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic [bta_pkg::WHO_W-1:0] t_who;

    typedef struct packed {
        bta_pkg::t_status                status;
        logic [bta_pkg::GIVEN_W-1:0]     given;
        logic                            grant_valid;
        logic [bta_pkg::WHO_W-1:0]       grant_index;
    } t_grant_beat;

    class t_ticket_scoreboard;
        bta_pkg::t_ticket tickets[bta_pkg::NUM_REQ];
        t_grant_beat      grants_due[$];
        int               errors;
        int               overflows;
        int               results;

        function new();
            foreach (tickets[i]) tickets[i] = '0;
            errors    = 0;
            overflows = 0;
            results   = 0;
        endfunction

        function bta_pkg::t_ticket top_ticket();
            bta_pkg::t_ticket top;
            top = '0;
            foreach (tickets[i]) if (tickets[i] > top) top = tickets[i];
            return top;
        endfunction

        // Apply one accepted beat to the ticket row and queue the grant it yields.
        function void take_beat(bta_pkg::t_action act, t_who who);
            t_grant_beat      exp;
            bta_pkg::t_ticket top;
            bta_pkg::t_ticket low;
            exp.status      = bta_pkg::ST_OK;
            exp.given       = '0;
            exp.grant_valid = 1'b0;
            exp.grant_index = '0;
            top = top_ticket();
            if (int'(who) >= bta_pkg::NUM_REQ) begin
                exp.status = bta_pkg::ST_IGNORED;
            end else if (act == bta_pkg::ACT_REQUEST) begin
                if (tickets[who] != 0) begin
                    exp.status = bta_pkg::ST_IGNORED;
                end else if (top == bta_pkg::TICKET_MAX) begin
                    exp.status = bta_pkg::ST_OVERFLOW;
                    overflows++;
                end else begin
                    tickets[who] = top + 1'b1;
                    exp.given    = tickets[who];
                end
            end else begin
                if (tickets[who] == 0) exp.status = bta_pkg::ST_IGNORED;
                else tickets[who] = '0;
            end
            low = '0;
            for (int i = 0; i < bta_pkg::NUM_REQ; i++) begin
                if (tickets[i] != 0 && (!exp.grant_valid || tickets[i] < low)) begin
                    exp.grant_valid = 1'b1;
                    exp.grant_index = i[bta_pkg::WHO_W-1:0];
                    low             = tickets[i];
                end
            end
            grants_due.push_back(exp);
        endfunction

        task report_mismatch(string msg);
            if (errors < 100) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_grant(logic [bta_pkg::STATUS_W-1:0] st, logic [bta_pkg::GIVEN_W-1:0] given,
                         logic gv, logic [bta_pkg::WHO_W-1:0] gi);
            t_grant_beat exp;
            results++;
            if (grants_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no beat pending", results));
                return;
            end
            exp = grants_due.pop_front();
            if (st !== exp.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                                          results, st, exp.status));
            if (given !== exp.given)
                report_mismatch($sformatf("result %0d ticket_given %0d, want %0d",
                                          results, given, exp.given));
            if (gv !== exp.grant_valid)
                report_mismatch($sformatf("result %0d grant_valid %b, want %b",
                                          results, gv, exp.grant_valid));
            if (gi !== exp.grant_index)
                report_mismatch($sformatf("result %0d grant_index %0d, want %0d",
                                          results, gi, exp.grant_index));
        endtask
    endclass

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic [bta_pkg::ACTION_W-1:0]       i_action    = '0;
    logic [bta_pkg::WHO_W-1:0]          i_requester = '0;
    logic                               i_out_stall = 1'b0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic [bta_pkg::STATUS_W-1:0]       o_status;
    logic [bta_pkg::GIVEN_W-1:0]        o_ticket_given;
    logic                               o_grant_valid;
    logic [bta_pkg::WHO_W-1:0]          o_grant_index;

    t_ticket_scoreboard sb = new();
    bit                 calm = 1'b0;
    int                 cycles = 0;

    bakery_ticket_arbiter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_requester    (i_requester),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_ticket_given (o_ticket_given),
        .o_grant_valid  (o_grant_valid),
        .o_grant_index  (o_grant_index)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_grant(o_status, o_ticket_given, o_grant_valid, o_grant_index);
    end

    // Result side: stall in bursts, none once the run has gone calm.
    initial begin : stall_bursts
        forever begin
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
            if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Present one beat from a falling edge, hold it until accepted, then maybe idle.
    task automatic send_beat(bta_pkg::t_action act, t_who who);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_requester <= who;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_beat(act, who);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        int               done;
        int               seg_len;
        int               mode;
        int               pal_a;
        int               pal_b;
        t_who             who;
        bta_pkg::t_action act;
        bit               holds;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty row, first tickets, duplicates, releases without a ticket.
        send_beat(bta_pkg::ACT_RELEASE, 4'd0);
        send_beat(bta_pkg::ACT_REQUEST, 4'd0);
        send_beat(bta_pkg::ACT_REQUEST, 4'd0);
        send_beat(bta_pkg::ACT_REQUEST, 4'd15);
        send_beat(bta_pkg::ACT_REQUEST, 4'd7);
        send_beat(bta_pkg::ACT_RELEASE, 4'd0);
        send_beat(bta_pkg::ACT_REQUEST, 4'd0);
        send_beat(bta_pkg::ACT_RELEASE, 4'd15);
        send_beat(bta_pkg::ACT_RELEASE, 4'd7);
        send_beat(bta_pkg::ACT_RELEASE, 4'd0);
        send_beat(bta_pkg::ACT_RELEASE, 4'd15);
        // Dropping the top holder must lower the next ticket handed out.
        send_beat(bta_pkg::ACT_REQUEST, 4'd8);
        send_beat(bta_pkg::ACT_REQUEST, 4'd5);
        send_beat(bta_pkg::ACT_REQUEST, 4'd10);
        send_beat(bta_pkg::ACT_RELEASE, 4'd8);
        send_beat(bta_pkg::ACT_RELEASE, 4'd10);
        send_beat(bta_pkg::ACT_REQUEST, 4'd3);
        send_beat(bta_pkg::ACT_REQUEST, 4'd12);
        send_beat(bta_pkg::ACT_RELEASE, 4'd5);
        send_beat(bta_pkg::ACT_RELEASE, 4'd12);
        send_beat(bta_pkg::ACT_RELEASE, 4'd3);
        send_beat(bta_pkg::ACT_REQUEST, 4'd3);

        done = 0;
        while (done < RANDOM_BEATS) begin
            seg_len = $urandom_range(10, 80);
            mode    = $urandom_range(0, 9);
            // Push the ticket count to its ceiling if the mix has not hit it three times yet.
            if (sb.overflows < 3 && done > 400) mode = 0;
            pal_a = $urandom_range(0, bta_pkg::NUM_REQ - 1);
            pal_b = (pal_a + $urandom_range(1, bta_pkg::NUM_REQ - 1)) % bta_pkg::NUM_REQ;
            for (int k = 0; k < seg_len && done < RANDOM_BEATS; k++) begin
                calm = (done >= RANDOM_BEATS - CALM_BEATS);
                who  = t_who'($urandom_range(0, bta_pkg::NUM_REQ - 1));
                act  = bta_pkg::t_action'($urandom_range(0, 1));
                if (mode <= 3 && $urandom_range(0, 7) != 0) begin
                    // Leapfrog two requesters so the top ticket keeps climbing.
                    if (sb.tickets[pal_a] != 0 && sb.tickets[pal_b] != 0) begin
                        act = bta_pkg::ACT_RELEASE;
                        who = (sb.tickets[pal_a] < sb.tickets[pal_b]) ?
                              pal_a[bta_pkg::WHO_W-1:0] : pal_b[bta_pkg::WHO_W-1:0];
                    end else if (sb.top_ticket() == bta_pkg::TICKET_MAX
                                 && $urandom_range(0, 2) == 0
                                 && (sb.tickets[pal_a] != 0 || sb.tickets[pal_b] != 0)) begin
                        act = bta_pkg::ACT_RELEASE;
                        who = (sb.tickets[pal_a] != 0) ?
                              pal_a[bta_pkg::WHO_W-1:0] : pal_b[bta_pkg::WHO_W-1:0];
                    end else begin
                        act = bta_pkg::ACT_REQUEST;
                        who = (sb.tickets[pal_a] == 0) ?
                              pal_a[bta_pkg::WHO_W-1:0] : pal_b[bta_pkg::WHO_W-1:0];
                    end
                end else if (mode <= 7) begin
                    holds = (sb.tickets[who] != 0);
                    if (holds) begin
                        act = ($urandom_range(0, 3) != 0) ?
                              bta_pkg::ACT_RELEASE : bta_pkg::ACT_REQUEST;
                    end else begin
                        act = ($urandom_range(0, 7) != 0) ?
                              bta_pkg::ACT_REQUEST : bta_pkg::ACT_RELEASE;
                    end
                end
                send_beat(act, who);
                done++;
            end
        end
        i_in_valid <= 1'b0;

        while (sb.grants_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
src/bta_pkg.sv
src/bta_cell.sv
src/bakery_ticket_arbiter.sv
src/bta_checker.sv
bench/bakery_ticket_arbiter_test.sv
